/* sv/prime_field_modular_unit_macros.svh */
// ----------------------------------------------------------------------------
// prime field modular unit: assertion macros
// shorthand for clocked assertions with reset disable, used by the checker
// ----------------------------------------------------------------------------
`ifndef PRIME_FIELD_MODULAR_UNIT_MACROS_SVH
`define PRIME_FIELD_MODULAR_UNIT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define PFM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define PFM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/pfm_pkg.sv */
// ----------------------------------------------------------------------------
// pfm_pkg
// types, constants and helpers for the prime field modular unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfm_pkg;

  localparam int ACTION_W         = 2;
  localparam int OPND_W           = 32;
  localparam int FIELD_W          = 30;
  localparam int OPERAND_BITS_DEF = 32;

  // modular multiplier internal widths
  localparam int PROD_W = 2 * FIELD_W;
  localparam int Q_W    = FIELD_W + 1;
  localparam int Q2_W   = 2 * Q_W;

  localparam logic [FIELD_W-1:0] MODULUS = 30'd1000000007;

  localparam logic [OPND_W-1:0] MOD_X1 = OPND_W'(MODULUS);
  localparam logic [OPND_W-1:0] MOD_X2 = 32'd2 * MOD_X1;
  localparam logic [OPND_W-1:0] MOD_X3 = 32'd3 * MOD_X1;
  localparam logic [OPND_W-1:0] MOD_X4 = 32'd4 * MOD_X1;

  // fermat inverse exponent
  localparam logic [OPND_W-1:0] INV_EXP = MOD_X1 - 32'd2;

  // barrett constant floor(2^60 / p)
  localparam logic [63:0]    MU_FULL    = (64'd1 << PROD_W) / 64'(MODULUS);
  localparam logic [Q_W-1:0] BARRETT_MU = MU_FULL[Q_W-1:0];

  typedef enum logic [ACTION_W-1:0] {
    ACT_MUL  = 2'd0,
    ACT_POW  = 2'd1,
    ACT_INV  = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_ISSUE_MUL,
    ST_WAIT,
    ST_DONE
  } state_t;

  typedef enum logic {
    TAG_SQ  = 1'b0,
    TAG_ACC = 1'b1
  } mm_tag_t;

  typedef struct packed {
    logic               valid;
    mm_tag_t            tag;
    logic [FIELD_W-1:0] x;
    logic [FIELD_W-1:0] y;
  } mm_req_t;

  typedef struct packed {
    logic               valid;
    mm_tag_t            tag;
    logic [FIELD_W-1:0] value;
    logic               busy;
  } mm_rsp_t;

  // reduce a 32-bit word mod p (any 32-bit value is below 5p)
  function automatic logic [FIELD_W-1:0] pfm_reduce(input logic [OPND_W-1:0] a);
    logic [OPND_W-1:0] r;
    priority if (a >= MOD_X4) begin
      r = a - MOD_X4;
    end else if (a >= MOD_X3) begin
      r = a - MOD_X3;
    end else if (a >= MOD_X2) begin
      r = a - MOD_X2;
    end else if (a >= MOD_X1) begin
      r = a - MOD_X1;
    end else begin
      r = a;
    end
    return r[FIELD_W-1:0];
  endfunction

endpackage

/* sv/pfm_req_if.sv */
// ----------------------------------------------------------------------------
// pfm_req_if
// request channel: action and two operands under valid/ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pfm_req_if import pfm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [OPND_W-1:0]   first_operand;
  logic [OPND_W-1:0]   second_operand;

  modport source (output valid, output action, output first_operand,
                  output second_operand, input ready);
  modport sink   (input valid, input action, input first_operand,
                  input second_operand, output ready);
endinterface

/* sv/pfm_rsp_if.sv */
// ----------------------------------------------------------------------------
// pfm_rsp_if
// result channel: field value under valid/ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pfm_rsp_if import pfm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

/* sv/pfm_modmul.sv */
// ----------------------------------------------------------------------------
// pfm_modmul
// five-stage modular multiplier, x * y mod p with barrett reduction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfm_modmul import pfm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  mm_req_t req,
  output mm_rsp_t rsp
);

  logic               v1, v2, v3, v4, v5;
  mm_tag_t            t1, t2, t3, t4, t5;
  logic [PROD_W-1:0]  prod1;
  logic [OPND_W-1:0]  xl2, xl3;
  logic [Q2_W-1:0]    q2;
  logic [OPND_W-1:0]  q3p;
  logic [OPND_W-1:0]  r4;
  logic [FIELD_W-1:0] val5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      v1 <= req.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    t1 <= req.tag;
    t2 <= t1;
    t3 <= t2;
    t4 <= t3;
    t5 <= t4;
    // full product, below p^2
    prod1 <= PROD_W'(req.x) * PROD_W'(req.y);
    // quotient estimate from the top 31 bits
    q2  <= Q2_W'(prod1[PROD_W-1:FIELD_W-1]) * Q2_W'(BARRETT_MU);
    xl2 <= prod1[OPND_W-1:0];
    // only the low word matters, the remainder is below 3p
    q3p <= OPND_W'(q2[Q2_W-1:Q_W]) * MOD_X1;
    xl3 <= xl2;
    r4  <= xl3 - q3p;
    val5 <= pfm_reduce(r4);
  end

  always_comb begin
    rsp.valid = v5;
    rsp.tag   = t5;
    rsp.value = val5;
    rsp.busy  = v1 | v2 | v3 | v4 | v5;
  end

endmodule

/* sv/prime_field_modular_unit.sv */
// ----------------------------------------------------------------------------
// prime_field_modular_unit
// multiply, power and fermat inverse modulo 1000000007
//
//   channel  dir  payload
//   req      in   action, first_operand, second_operand
//   rsp      out  value
//
// one request at a time; req.ready is high only while idle.
// right-to-left square-and-multiply on one five-stage modular multiplier:
// each exponent bit up to the top set bit takes a square, each set bit also a
// multiply; square and multiply overlap in the pipe, and the next bit waits
// until the pipe is empty. action 3 gives 0.
// rst is synchronous and returns to idle; the result waits in rsp until taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prime_field_modular_unit import pfm_pkg::*; #(
  parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  pfm_req_if.sink      req,
  pfm_rsp_if.source    rsp
);

  // exponent bits that can be nonzero
  localparam int EXP_W = (OPERAND_BITS < OPND_W) ? OPERAND_BITS : OPND_W;

  state_t             state, state_next;
  logic [FIELD_W-1:0] acc, acc_next;
  logic [FIELD_W-1:0] sq, sq_next;
  logic [EXP_W-1:0]   expo, expo_next;
  logic [FIELD_W-1:0] a_red, b_red;
  mm_req_t            mm_req;
  mm_rsp_t            mm_rsp;

  pfm_modmul u_modmul (
    .clk (clk),
    .rst (rst),
    .req (mm_req),
    .rsp (mm_rsp)
  );

  assign a_red = pfm_reduce(OPND_W'(req.first_operand[EXP_W-1:0]));
  assign b_red = pfm_reduce(OPND_W'(req.second_operand[EXP_W-1:0]));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    acc  <= acc_next;
    sq   <= sq_next;
    expo <= expo_next;
  end

  always_comb begin
    state_next = state;
    acc_next   = acc;
    sq_next    = sq;
    expo_next  = expo;
    mm_req.valid = 1'b0;
    mm_req.tag   = TAG_SQ;
    mm_req.x     = sq;
    mm_req.y     = sq;

    if (mm_rsp.valid) begin
      if (mm_rsp.tag == TAG_ACC) begin
        acc_next = mm_rsp.value;
      end else begin
        sq_next = mm_rsp.value;
      end
    end

    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next = ST_ISSUE;
          unique case (action_t'(req.action))
            ACT_MUL: begin
              // one step with exponent 1 leaves acc * sq
              acc_next  = a_red;
              sq_next   = b_red;
              expo_next = EXP_W'(1);
            end
            ACT_POW: begin
              acc_next  = FIELD_W'(1);
              sq_next   = a_red;
              expo_next = req.second_operand[EXP_W-1:0];
            end
            ACT_INV: begin
              acc_next  = FIELD_W'(1);
              sq_next   = a_red;
              expo_next = INV_EXP[EXP_W-1:0];
            end
            ACT_NONE: begin
              acc_next  = '0;
              sq_next   = '0;
              expo_next = '0;
            end
            default: begin
              acc_next  = '0;
              sq_next   = '0;
              expo_next = '0;
            end
          endcase
        end
      end
      ST_ISSUE: begin
        if (expo == '0) begin
          state_next = ST_DONE;
        end else begin
          mm_req.valid = 1'b1;
          mm_req.tag   = TAG_SQ;
          expo_next    = expo >> 1;
          state_next   = expo[0] ? ST_ISSUE_MUL : ST_WAIT;
        end
      end
      ST_ISSUE_MUL: begin
        // sq still holds the old square here
        mm_req.valid = 1'b1;
        mm_req.tag   = TAG_ACC;
        mm_req.x     = acc;
        state_next   = ST_WAIT;
      end
      ST_WAIT: begin
        if (!mm_rsp.busy) begin
          state_next = ST_ISSUE;
        end
      end
      ST_DONE: begin
        if (rsp.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign req.ready = (state == ST_IDLE);
  assign rsp.valid = (state == ST_DONE);
  assign rsp.value = acc;

endmodule

/* sv/pfm_checker.sv */
// ----------------------------------------------------------------------------
// pfm_checker
// port-level checks for the prime field modular unit, bound to the top
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "prime_field_modular_unit_macros.svh"

module pfm_checker import pfm_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic [FIELD_W-1:0] rsp_value
);

  `PFM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_value), "result changed while stalled")
  `PFM_ASSERT_NOW(a_rsp_range, rsp_valid, rsp_value < MODULUS, "result not reduced below p")
  `PFM_ASSERT_NEXT(a_req_busy, req_valid && req_ready, !req_ready && !rsp_valid, "request not held after accept")
  `PFM_ASSERT_NOW(a_one_item, rsp_valid, !req_ready, "request taken while result pending")

endmodule

bind prime_field_modular_unit pfm_checker u_pfm_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_value (rsp.value)
);
